// File: sv/aalc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC averaging and calibration package
// Shared widths, register indexes, reset values and the sequencer states.
// ----------------------------------------------------------------------------
package aalc_pkg;

	localparam int SAMPLE_W = 12;
	localparam int TEMP_W   = 16;
	localparam int DT_W     = 16;
	localparam int QUO_W    = 18;
	localparam int AVG_W    = 15;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic [1:0] REG_CAL_SAMPLE_LOW  = 2'd0;
	localparam logic [1:0] REG_CAL_TEMP_LOW    = 2'd1;
	localparam logic [1:0] REG_CAL_SAMPLE_HIGH = 2'd2;
	localparam logic [1:0] REG_CAL_TEMP_HIGH   = 2'd3;

	localparam logic [SAMPLE_W-1:0]      CAL_SAMPLE_LOW_RST  = 12'd684;
	localparam logic signed [TEMP_W-1:0] CAL_TEMP_LOW_RST    = -16'sd5170;
	localparam logic [SAMPLE_W-1:0]      CAL_SAMPLE_HIGH_RST = 12'd2496;
	localparam logic signed [TEMP_W-1:0] CAL_TEMP_HIGH_RST   = 16'sd7976;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_PREP,
		ST_MUL,
		ST_NORM1,
		ST_NORM2,
		ST_DIV,
		ST_FINAL
	} state_t;

endpackage
`default_nettype wire

// File: sv/aalc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module aalc_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: sv/aalc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial restoring divider
// Unsigned division producing one quotient bit per cycle, most significant
// first. The dividend must be below the divisor shifted left by QW bits.
// ----------------------------------------------------------------------------
module aalc_div #(
	parameter int NW = 33,
	parameter int DW = 16,
	parameter int QW = 18
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [QW-1:0] quotient,
	output logic          rem_nz
);

	localparam int RW = (NW > DW + QW - 1) ? NW : DW + QW - 1;
	localparam int CW = $clog2(QW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] dvs_q;
	logic [QW-1:0] quo_q;
	logic          ge;

	assign ge = rem_q >= dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= RW'(dividend);
			dvs_q <= RW'(divisor) << (QW - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_q - dvs_q : rem_q;
			dvs_q <= dvs_q >> 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
	assign rem_nz   = |rem_q;

endmodule
`default_nettype wire

// File: sv/adc_average_linear_calibration_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A result is loaded into the output register after the item passes the sum, prepare,
// multiply, normalise, divide and final states; the final state waits for a free output.
// A new item is accepted only in the idle state, once the previous result is loaded, so
// the bit-serial multiplier and the one-bit-per-cycle divider serve one item at a time.
// Reset marks every ring slot empty and clears the running sum, the previous values and
// the control state, and loads the calibration registers with their default points.
// ----------------------------------------------------------------------------
// ADC averaging unit with linear calibration
// Assembles a 12-bit sample, keeps a running sum over a ring of samples and
// maps the average to a rounded, saturated temperature through two points.
// ----------------------------------------------------------------------------
module adc_average_linear_calibration_unit #(
	parameter int RING_DEPTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [aalc_pkg::ADDR_W-1:0]       paddr,
	input  logic [aalc_pkg::DATA_W-1:0]       pwdata,
	output logic [aalc_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              reply_valid,
	output logic                              reply_ready,
	input  logic [7:0]                        reply_high,
	input  logic [7:0]                        reply_low,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [aalc_pkg::SAMPLE_W-1:0]     sample,
	output logic [aalc_pkg::AVG_W-1:0]        average_x8,
	output logic signed [aalc_pkg::TEMP_W-1:0] temperature,
	output logic                              saturated,
	output logic                              fit_error,
	output logic                              temp_changed,
	output logic                              sample_changed
);

	localparam int SW     = aalc_pkg::SAMPLE_W;
	localparam int TW     = aalc_pkg::TEMP_W;
	localparam int QW     = aalc_pkg::QUO_W;
	localparam int PTR_W  = $clog2(RING_DEPTH);
	localparam int DEP_W  = $clog2(RING_DEPTH + 1);
	localparam int SUM_W  = SW + $clog2(RING_DEPTH);
	localparam int PROD_W = SUM_W + aalc_pkg::DT_W;
	localparam int NMAG_W = PROD_W + 2;
	localparam int MC_W   = $clog2(SUM_W + 1);
	localparam int FW     = QW + 2;
	localparam logic signed [FW-1:0] TEMP_MAX = FW'(32767);
	localparam logic signed [FW-1:0] TEMP_MIN = -(FW'(32768));

	aalc_pkg::state_t state_q, state_d;

	logic [SW-1:0]        cal_sample_low_q;
	logic signed [TW-1:0] cal_temp_low_q;
	logic [SW-1:0]        cal_sample_high_q;
	logic signed [TW-1:0] cal_temp_high_q;

	logic                  accept;
	logic                  out_load;
	logic [SW-1:0]         sample_q;
	logic [PTR_W-1:0]      ptr_q;
	logic [RING_DEPTH-1:0] valid_q;
	logic [SUM_W-1:0]      sum_q;
	logic [SW-1:0]         ram_rdata;
	logic [SW-1:0]         old_sample;
	logic signed [TW-1:0]  prev_temp_q;
	logic [SW-1:0]         prev_sample_q;

	logic [TW:0]          dt;
	logic [aalc_pkg::DT_W-1:0] dt_mag;
	logic [SUM_W-1:0]     csl_scaled;
	logic                 dx_neg;
	logic [SUM_W-1:0]     dx_mag;
	logic                 den_neg;
	logic [SW-1:0]        diff_mag;

	logic [aalc_pkg::DT_W-1:0] mcand_q;
	logic [PROD_W-1:0]    prod_q;
	logic [aalc_pkg::DT_W:0] mul_add;
	logic [MC_W-1:0]      mul_cnt_q;
	logic                 neg_q;
	logic [SUM_W-1:0]     den_q;
	logic                 fit_q;

	logic [NMAG_W-1:0]    num2;
	logic [NMAG_W-1:0]    dext;
	logic [NMAG_W-1:0]    nmag_q;
	logic                 nneg_q;
	logic                 big_q;

	logic                 tdiv_busy;
	logic [QW-1:0]        tquo;
	logic                 trnz;
	logic                 avg_busy;
	logic [aalc_pkg::AVG_W-1:0] avg_quo;

	logic [QW:0]          qa;
	logic signed [FW-1:0] qs;
	logic signed [FW-1:0] total;
	logic signed [TW-1:0] temp_fin;
	logic                 sat_fin;

	logic                 result_valid_q;
	logic [SW-1:0]        sample_out_q;
	logic [aalc_pkg::AVG_W-1:0] avg_out_q;
	logic signed [TW-1:0] temp_out_q;
	logic                 sat_out_q;
	logic                 fit_out_q;
	logic                 tchg_out_q;
	logic                 schg_out_q;

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_sample_low_q  <= aalc_pkg::CAL_SAMPLE_LOW_RST;
			cal_temp_low_q    <= aalc_pkg::CAL_TEMP_LOW_RST;
			cal_sample_high_q <= aalc_pkg::CAL_SAMPLE_HIGH_RST;
			cal_temp_high_q   <= aalc_pkg::CAL_TEMP_HIGH_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				aalc_pkg::REG_CAL_SAMPLE_LOW:  cal_sample_low_q  <= pwdata[SW-1:0];
				aalc_pkg::REG_CAL_TEMP_LOW:    cal_temp_low_q    <= pwdata[TW-1:0];
				aalc_pkg::REG_CAL_SAMPLE_HIGH: cal_sample_high_q <= pwdata[SW-1:0];
				aalc_pkg::REG_CAL_TEMP_HIGH:   cal_temp_high_q   <= pwdata[TW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			aalc_pkg::REG_CAL_SAMPLE_LOW:
				prdata = {{(aalc_pkg::DATA_W-SW){1'b0}}, cal_sample_low_q};
			aalc_pkg::REG_CAL_TEMP_LOW:
				prdata = {{(aalc_pkg::DATA_W-TW){cal_temp_low_q[TW-1]}}, cal_temp_low_q};
			aalc_pkg::REG_CAL_SAMPLE_HIGH:
				prdata = {{(aalc_pkg::DATA_W-SW){1'b0}}, cal_sample_high_q};
			aalc_pkg::REG_CAL_TEMP_HIGH:
				prdata = {{(aalc_pkg::DATA_W-TW){cal_temp_high_q[TW-1]}}, cal_temp_high_q};
			default:
				prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aalc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		reply_ready = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			aalc_pkg::ST_IDLE: begin
				reply_ready = 1'b1;
				if (reply_valid) begin
					state_d = aalc_pkg::ST_SUM;
				end
			end
			aalc_pkg::ST_SUM:   state_d = aalc_pkg::ST_PREP;
			aalc_pkg::ST_PREP:  state_d = aalc_pkg::ST_MUL;
			aalc_pkg::ST_MUL: begin
				if (mul_cnt_q == MC_W'(1)) begin
					state_d = aalc_pkg::ST_NORM1;
				end
			end
			aalc_pkg::ST_NORM1: state_d = aalc_pkg::ST_NORM2;
			aalc_pkg::ST_NORM2: state_d = aalc_pkg::ST_DIV;
			aalc_pkg::ST_DIV: begin
				if (!tdiv_busy) begin
					state_d = aalc_pkg::ST_FINAL;
				end
			end
			aalc_pkg::ST_FINAL: begin
				if (!avg_busy && (!result_valid_q || result_ready)) begin
					out_load = 1'b1;
					state_d  = aalc_pkg::ST_IDLE;
				end
			end
			default: state_d = aalc_pkg::ST_IDLE;
		endcase
	end

	assign accept = reply_valid && reply_ready;

	// Sample ring with running sum.
	aalc_ram #(
		.WIDTH(SW),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (state_q == aalc_pkg::ST_SUM),
		.waddr(ptr_q),
		.wdata(sample_q),
		.re   (accept),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	assign old_sample = valid_q[ptr_q] ? ram_rdata : '0;

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= {reply_high[3:0], reply_low};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q         <= '0;
			valid_q       <= '0;
			sum_q         <= '0;
			prev_temp_q   <= '0;
			prev_sample_q <= '0;
		end else begin
			if (state_q == aalc_pkg::ST_SUM) begin
				sum_q          <= sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
				valid_q[ptr_q] <= 1'b1;
				ptr_q          <= (ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_q + PTR_W'(1);
			end
			if (out_load) begin
				prev_temp_q   <= temp_fin;
				prev_sample_q <= sample_q;
			end
		end
	end

	// Line terms in sign and magnitude form.
	assign dt         = {cal_temp_high_q[TW-1], cal_temp_high_q}
	                  - {cal_temp_low_q[TW-1], cal_temp_low_q};
	assign dt_mag     = dt[TW] ? aalc_pkg::DT_W'(~dt + 1'b1) : dt[TW-1:0];
	assign csl_scaled = SUM_W'(32'(cal_sample_low_q) * 32'(RING_DEPTH));
	assign dx_neg     = sum_q < csl_scaled;
	assign dx_mag     = dx_neg ? csl_scaled - sum_q : sum_q - csl_scaled;
	assign den_neg    = cal_sample_high_q < cal_sample_low_q;
	assign diff_mag   = den_neg ? cal_sample_low_q - cal_sample_high_q
	                            : cal_sample_high_q - cal_sample_low_q;

	assign mul_add = {1'b0, prod_q[PROD_W-1:SUM_W]}
	               + (prod_q[0] ? {1'b0, mcand_q} : '0);

	assign num2 = NMAG_W'({prod_q, 1'b0});
	assign dext = NMAG_W'(den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_cnt_q <= '0;
		end else if (state_q == aalc_pkg::ST_PREP) begin
			mul_cnt_q <= MC_W'(SUM_W);
		end else if (state_q == aalc_pkg::ST_MUL) begin
			mul_cnt_q <= mul_cnt_q - MC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			aalc_pkg::ST_PREP: begin
				mcand_q <= dt_mag;
				prod_q  <= {{aalc_pkg::DT_W{1'b0}}, dx_mag};
				neg_q   <= dt[TW] ^ dx_neg ^ den_neg;
				den_q   <= SUM_W'(32'(diff_mag) * 32'(RING_DEPTH));
				fit_q   <= cal_sample_high_q == cal_sample_low_q;
			end
			aalc_pkg::ST_MUL: begin
				prod_q <= {mul_add, prod_q[SUM_W-1:1]};
			end
			aalc_pkg::ST_NORM1: begin
				if (!neg_q) begin
					nmag_q <= num2 + dext;
					nneg_q <= 1'b0;
				end else if (num2 > dext) begin
					nmag_q <= num2 - dext;
					nneg_q <= 1'b1;
				end else begin
					nmag_q <= dext - num2;
					nneg_q <= 1'b0;
				end
			end
			aalc_pkg::ST_NORM2: begin
				big_q <= {1'b0, nmag_q} >= {den_q, 1'b0, {QW{1'b0}}};
			end
			default: ;
		endcase
	end

	aalc_div #(
		.NW(NMAG_W),
		.DW(SUM_W + 1),
		.QW(QW)
	) u_temp_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == aalc_pkg::ST_NORM2),
		.dividend(nmag_q),
		.divisor ({den_q, 1'b0}),
		.busy    (tdiv_busy),
		.quotient(tquo),
		.rem_nz  (trnz)
	);

	aalc_div #(
		.NW(SUM_W + 3),
		.DW(DEP_W),
		.QW(aalc_pkg::AVG_W)
	) u_avg_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == aalc_pkg::ST_PREP),
		.dividend({sum_q, 3'b000}),
		.divisor (DEP_W'(RING_DEPTH)),
		.busy    (avg_busy),
		.quotient(avg_quo),
		.rem_nz  ()
	);

	// Floor of the signed quotient, offset, rounding already folded in.
	assign qa    = {1'b0, tquo} + (QW + 1)'(trnz);
	assign qs    = nneg_q ? -$signed({1'b0, qa}) : $signed({2'b00, tquo});
	assign total = $signed({{(FW - TW){cal_temp_low_q[TW-1]}}, cal_temp_low_q}) + qs;

	always_comb begin
		if (fit_q) begin
			temp_fin = '0;
			sat_fin  = 1'b0;
		end else if (big_q) begin
			temp_fin = nneg_q ? TW'(TEMP_MIN) : TW'(TEMP_MAX);
			sat_fin  = 1'b1;
		end else if (total > TEMP_MAX) begin
			temp_fin = TW'(TEMP_MAX);
			sat_fin  = 1'b1;
		end else if (total < TEMP_MIN) begin
			temp_fin = TW'(TEMP_MIN);
			sat_fin  = 1'b1;
		end else begin
			temp_fin = total[TW-1:0];
			sat_fin  = 1'b0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_out_q <= sample_q;
			avg_out_q    <= avg_quo;
			temp_out_q   <= temp_fin;
			sat_out_q    <= sat_fin;
			fit_out_q    <= fit_q;
			tchg_out_q   <= temp_fin != prev_temp_q;
			schg_out_q   <= sample_q != prev_sample_q;
		end
	end

	assign result_valid   = result_valid_q;
	assign sample         = sample_out_q;
	assign average_x8     = avg_out_q;
	assign temperature    = temp_out_q;
	assign saturated      = sat_out_q;
	assign fit_error      = fit_out_q;
	assign temp_changed   = tchg_out_q;
	assign sample_changed = schg_out_q;

endmodule
`default_nettype wire

// File: sv/aalc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC averaging unit checker
// Port-level checks on the item channels and on the result flags.
// ----------------------------------------------------------------------------
module aalc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        reply_valid,
	input wire        reply_ready,
	input wire        result_valid,
	input wire        result_ready,
	input wire [11:0] sample,
	input wire [15:0] temperature,
	input wire        saturated,
	input wire        fit_error
);

	// A result that is not taken holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(temperature) && $stable(sample))
		else $error("result changed while stalled");

	// The unit works on one item at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && reply_ready |=> !reply_ready)
		else $error("item taken while busy");

	a_fit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && fit_error |-> temperature == 16'h0000 && !saturated)
		else $error("fit error without zero temperature");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |-> temperature == 16'h7FFF || temperature == 16'h8000)
		else $error("saturated temperature not at a limit");

endmodule

bind adc_average_linear_calibration_unit aalc_checker u_aalc_checker (.*);
`default_nettype wire

// File: tb/sv/aalc_reading_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reading checker for the ADC averaging and calibration unit
// Watches the register port and both item channels, keeps its own copy of the
// sample ring, previous values and calibration points, predicts each result
// and compares every field of every accepted result against the oldest one.
// ----------------------------------------------------------------------------
module aalc_reading_checker #(
	parameter int RING_DEPTH = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [aalc_pkg::ADDR_W-1:0]        paddr,
	input  logic [aalc_pkg::DATA_W-1:0]        pwdata,
	input  logic [aalc_pkg::DATA_W-1:0]        prdata,
	input  logic                               pready,
	input  logic                               reply_valid,
	input  logic                               reply_ready,
	input  logic [7:0]                         reply_high,
	input  logic [7:0]                         reply_low,
	input  logic                               result_valid,
	input  logic                               result_ready,
	input  logic [aalc_pkg::SAMPLE_W-1:0]      sample,
	input  logic [aalc_pkg::AVG_W-1:0]         average_x8,
	input  logic signed [aalc_pkg::TEMP_W-1:0] temperature,
	input  logic                               saturated,
	input  logic                               fit_error,
	input  logic                               temp_changed,
	input  logic                               sample_changed,
	output int                                 mismatches,
	output int                                 outstanding,
	output int                                 results_checked,
	output int                                 saturations,
	output int                                 fit_errors
);

	typedef struct {
		logic [aalc_pkg::SAMPLE_W-1:0]      sample;
		logic [aalc_pkg::AVG_W-1:0]         average_x8;
		logic signed [aalc_pkg::TEMP_W-1:0] temperature;
		logic                               saturated;
		logic                               fit_error;
		logic                               temp_changed;
		logic                               sample_changed;
	} reading_t;

	logic [aalc_pkg::SAMPLE_W-1:0]      sample_ring [RING_DEPTH];
	int                                 ring_slot;
	logic signed [aalc_pkg::TEMP_W-1:0] last_temperature;
	logic [aalc_pkg::SAMPLE_W-1:0]      last_sample;
	logic [aalc_pkg::SAMPLE_W-1:0]      point_lo_sample;
	logic signed [aalc_pkg::TEMP_W-1:0] point_lo_temp;
	logic [aalc_pkg::SAMPLE_W-1:0]      point_hi_sample;
	logic signed [aalc_pkg::TEMP_W-1:0] point_hi_temp;
	reading_t                           expected_readings [$];

	function automatic reading_t calibrate_reading(input logic [7:0] hi, input logic [7:0] lo);
		reading_t r;
		longint   ring_sum;
		longint   dt;
		longint   dx;
		longint   num;
		longint   den;
		longint   quo;
		longint   total;
		r.sample = {hi[3:0], lo};
		sample_ring[ring_slot] = r.sample;
		ring_slot = (ring_slot + 1) % RING_DEPTH;
		ring_sum = 0;
		for (int i = 0; i < RING_DEPTH; i++)
			ring_sum += longint'(sample_ring[i]);
		r.average_x8 = aalc_pkg::AVG_W'((ring_sum * 8) / RING_DEPTH);
		r.saturated = 1'b0;
		r.fit_error = 1'b0;
		if (point_hi_sample == point_lo_sample) begin
			r.fit_error = 1'b1;
			r.temperature = '0;
		end else begin
			dt = longint'(point_hi_temp) - longint'(point_lo_temp);
			dx = ring_sum - longint'(point_lo_sample) * RING_DEPTH;
			num = dt * dx;
			den = (longint'(point_hi_sample) - longint'(point_lo_sample)) * RING_DEPTH;
			if (den < 0) begin
				den = -den;
				num = -num;
			end
			// Round half up: floor((2*num + den) / (2*den)).
			quo = (2 * num + den) / (2 * den);
			if ((2 * num + den) % (2 * den) != 0 && (2 * num + den) < 0)
				quo--;
			total = longint'(point_lo_temp) + quo;
			if (total > 32767) begin
				total = 32767;
				r.saturated = 1'b1;
			end else if (total < -32768) begin
				total = -32768;
				r.saturated = 1'b1;
			end
			r.temperature = aalc_pkg::TEMP_W'(total);
		end
		r.temp_changed = (r.temperature != last_temperature);
		r.sample_changed = (r.sample != last_sample);
		last_temperature = r.temperature;
		last_sample = r.sample;
		return r;
	endfunction

	task automatic compare_field(input string field, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reading_t   want;
		logic [1:0] reg_index;
		if (!arst_n) begin
			foreach (sample_ring[i])
				sample_ring[i] = '0;
			ring_slot = 0;
			last_temperature = '0;
			last_sample = '0;
			point_lo_sample = aalc_pkg::CAL_SAMPLE_LOW_RST;
			point_lo_temp = aalc_pkg::CAL_TEMP_LOW_RST;
			point_hi_sample = aalc_pkg::CAL_SAMPLE_HIGH_RST;
			point_hi_temp = aalc_pkg::CAL_TEMP_HIGH_RST;
			expected_readings.delete();
			mismatches = 0;
			outstanding = 0;
			results_checked = 0;
			saturations = 0;
			fit_errors = 0;
		end else begin
			reg_index = paddr[3:2];
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_index)
						aalc_pkg::REG_CAL_SAMPLE_LOW:
							point_lo_sample = pwdata[aalc_pkg::SAMPLE_W-1:0];
						aalc_pkg::REG_CAL_TEMP_LOW:
							point_lo_temp = pwdata[aalc_pkg::TEMP_W-1:0];
						aalc_pkg::REG_CAL_SAMPLE_HIGH:
							point_hi_sample = pwdata[aalc_pkg::SAMPLE_W-1:0];
						aalc_pkg::REG_CAL_TEMP_HIGH:
							point_hi_temp = pwdata[aalc_pkg::TEMP_W-1:0];
						default: ;
					endcase
				end else begin
					case (reg_index)
						aalc_pkg::REG_CAL_SAMPLE_LOW:
							compare_field("cal_sample_low readback", point_lo_sample,
								prdata[aalc_pkg::SAMPLE_W-1:0]);
						aalc_pkg::REG_CAL_TEMP_LOW:
							compare_field("cal_temp_low readback", point_lo_temp,
								$signed(prdata[aalc_pkg::TEMP_W-1:0]));
						aalc_pkg::REG_CAL_SAMPLE_HIGH:
							compare_field("cal_sample_high readback", point_hi_sample,
								prdata[aalc_pkg::SAMPLE_W-1:0]);
						aalc_pkg::REG_CAL_TEMP_HIGH:
							compare_field("cal_temp_high readback", point_hi_temp,
								$signed(prdata[aalc_pkg::TEMP_W-1:0]));
						default: ;
					endcase
				end
			end
			if (reply_valid && reply_ready)
				expected_readings.push_back(calibrate_reading(reply_high, reply_low));
			if (result_valid && result_ready) begin
				if (expected_readings.size() == 0) begin
					$display("%0t ns: result with no item waiting, actual sample %0d temperature %0d",
						$time, sample, temperature);
					mismatches++;
				end else begin
					want = expected_readings.pop_front();
					compare_field("sample", want.sample, sample);
					compare_field("average_x8", want.average_x8, average_x8);
					compare_field("temperature", want.temperature, temperature);
					compare_field("saturated", want.saturated, saturated);
					compare_field("fit_error", want.fit_error, fit_error);
					compare_field("temp_changed", want.temp_changed, temp_changed);
					compare_field("sample_changed", want.sample_changed, sample_changed);
					results_checked++;
					saturations += int'(want.saturated);
					fit_errors += int'(want.fit_error);
				end
			end
			outstanding = expected_readings.size();
		end
	end

endmodule

// File: tb/sv/adc_average_linear_calibration_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the ADC averaging and calibration unit
// Drives converter reply items through a series of calibration settings, from
// the reset points to the extremes, with random gaps on both channels and one
// long receiver hold, and reports the verdict from the reading checker.
// ----------------------------------------------------------------------------
module adc_average_linear_calibration_unit_tb;

	localparam int RING_DEPTH = 8;
	localparam int DRAIN_CYCLES = 50;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                psel;
	logic                                penable;
	logic                                pwrite;
	logic [aalc_pkg::ADDR_W-1:0]         paddr;
	logic [aalc_pkg::DATA_W-1:0]         pwdata;
	logic [aalc_pkg::DATA_W-1:0]         prdata;
	logic                                pready;
	logic                                reply_valid;
	logic                                reply_ready;
	logic [7:0]                          reply_high;
	logic [7:0]                          reply_low;
	logic                                result_valid;
	logic                                result_ready;
	logic [aalc_pkg::SAMPLE_W-1:0]       sample;
	logic [aalc_pkg::AVG_W-1:0]          average_x8;
	logic signed [aalc_pkg::TEMP_W-1:0]  temperature;
	logic                                saturated;
	logic                                fit_error;
	logic                                temp_changed;
	logic                                sample_changed;

	int                        mismatches;
	int                        outstanding;
	int                        results_checked;
	int                        saturations;
	int                        fit_errors;

	bit                        idle_on = 1'b1;
	bit                        hold_request = 1'b0;
	bit                        hold_served = 1'b0;
	int                        settings_used = 1;
	logic [7:0]                prev_high = '0;
	logic [7:0]                prev_low = '0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	adc_average_linear_calibration_unit #(
		.RING_DEPTH(RING_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.reply_valid(reply_valid),
		.reply_ready(reply_ready),
		.reply_high(reply_high),
		.reply_low(reply_low),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.sample(sample),
		.average_x8(average_x8),
		.temperature(temperature),
		.saturated(saturated),
		.fit_error(fit_error),
		.temp_changed(temp_changed),
		.sample_changed(sample_changed)
	);

	aalc_reading_checker #(
		.RING_DEPTH(RING_DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.reply_valid(reply_valid),
		.reply_ready(reply_ready),
		.reply_high(reply_high),
		.reply_low(reply_low),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.sample(sample),
		.average_x8(average_x8),
		.temperature(temperature),
		.saturated(saturated),
		.fit_error(fit_error),
		.temp_changed(temp_changed),
		.sample_changed(sample_changed),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.results_checked(results_checked),
		.saturations(saturations),
		.fit_errors(fit_errors)
	);

	task automatic register_access(input bit is_write, input logic [1:0] reg_index,
			input logic [aalc_pkg::DATA_W-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = is_write;
		paddr = {reg_index, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic offer_reading(input logic [7:0] hi, input logic [7:0] lo);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			reply_valid = 1'b0;
			gap = $urandom_range(1, 13);
			repeat (gap) @(negedge clk);
		end
		reply_high = hi;
		reply_low = lo;
		reply_valid = 1'b1;
		do
			@(posedge clk);
		while (!reply_ready);
		prev_high = hi;
		prev_low = lo;
	endtask

	task automatic apply_calibration(input logic [aalc_pkg::SAMPLE_W-1:0] lo_sample,
			input logic [aalc_pkg::TEMP_W-1:0] lo_temp,
			input logic [aalc_pkg::SAMPLE_W-1:0] hi_sample,
			input logic [aalc_pkg::TEMP_W-1:0] hi_temp);
		@(negedge clk);
		reply_valid = 1'b0;
		wait (outstanding == 0);
		repeat (45) @(negedge clk);
		register_access(1'b1, aalc_pkg::REG_CAL_SAMPLE_LOW, aalc_pkg::DATA_W'(lo_sample));
		register_access(1'b1, aalc_pkg::REG_CAL_TEMP_LOW, {{16{lo_temp[15]}}, lo_temp});
		register_access(1'b1, aalc_pkg::REG_CAL_SAMPLE_HIGH, aalc_pkg::DATA_W'(hi_sample));
		register_access(1'b1, aalc_pkg::REG_CAL_TEMP_HIGH, {{16{hi_temp[15]}}, hi_temp});
		register_access(1'b0, aalc_pkg::REG_CAL_SAMPLE_LOW, '0);
		register_access(1'b0, aalc_pkg::REG_CAL_TEMP_LOW, '0);
		register_access(1'b0, aalc_pkg::REG_CAL_SAMPLE_HIGH, '0);
		register_access(1'b0, aalc_pkg::REG_CAL_TEMP_HIGH, '0);
		settings_used++;
	endtask

	// Mostly random readings, with repeats, rail values and slow drift so the
	// change flags and a settled ring are exercised.
	task automatic random_readings(input int count);
		int                            mode;
		int                            level;
		logic [aalc_pkg::SAMPLE_W-1:0] value;
		repeat (count) begin
			mode = $urandom_range(0, 9);
			value = aalc_pkg::SAMPLE_W'($urandom);
			if (mode <= 1) begin
				value = {prev_high[3:0], prev_low};
			end else if (mode == 2) begin
				value = $urandom_range(0, 1) ? '1 : '0;
			end else if (mode <= 4) begin
				level = int'({prev_high[3:0], prev_low}) + $urandom_range(0, 6) - 3;
				value = (level < 0) ? '0 : (level > 4095) ? '1 : aalc_pkg::SAMPLE_W'(level);
			end
			offer_reading({4'($urandom), value[11:8]}, value[7:0]);
		end
	endtask

	initial begin : result_sink
		int n;
		result_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_request && !hold_served) begin
				result_ready = 1'b0;
				repeat (400) @(negedge clk);
				hold_served = 1'b1;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				result_ready = 1'b0;
				n = $urandom_range(1, 13);
				repeat (n - 1) @(negedge clk);
			end else begin
				result_ready = 1'b1;
				if (idle_on) begin
					n = $urandom_range(1, 30);
					repeat (n - 1) @(negedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		reply_valid = 1'b0;
		reply_high = '0;
		reply_low = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset calibration: rails, ignored high nibble, repeats and walking bits.
		offer_reading(8'h00, 8'h00);
		offer_reading(8'hF0, 8'h00);
		offer_reading(8'h0F, 8'hFF);
		offer_reading(8'hFF, 8'hFF);
		offer_reading(8'h0F, 8'hFF);
		offer_reading(8'hAF, 8'hFF);
		offer_reading(8'h5F, 8'hFF);
		offer_reading(8'h0F, 8'hFF);
		offer_reading(8'h0F, 8'hFF);
		offer_reading(8'h0F, 8'hFF);
		offer_reading(8'h08, 8'h00);
		offer_reading(8'h07, 8'hFF);
		offer_reading(8'h0A, 8'h55);
		offer_reading(8'h05, 8'hAA);
		offer_reading(8'h80, 8'h01);
		offer_reading(8'h40, 8'h02);
		offer_reading(8'h20, 8'h04);
		offer_reading(8'h10, 8'h08);
		offer_reading(8'h01, 8'h10);
		offer_reading(8'h02, 8'h20);
		offer_reading(8'h04, 8'h40);
		offer_reading(8'h00, 8'h80);
		random_readings(70);

		apply_calibration(12'd0, 16'h8000, 12'd4095, 16'h7FFF);
		hold_request = 1'b1;
		random_readings(90);
		apply_calibration(12'd2048, 16'h0000, 12'd2049, 16'h7FFF);
		random_readings(90);
		apply_calibration(12'd1234, 16'd100, 12'd1234, -16'sd100);
		random_readings(60);
		apply_calibration(12'd4095, 16'h7FFF, 12'd0, 16'h8000);
		random_readings(90);
		apply_calibration(12'd0, 16'd0, 12'd1, 16'd1);
		random_readings(90);
		apply_calibration(12'd0, 16'd0, 12'd1, -16'sd1);
		random_readings(90);
		repeat (3) begin
			apply_calibration(aalc_pkg::SAMPLE_W'($urandom), aalc_pkg::TEMP_W'($urandom),
				aalc_pkg::SAMPLE_W'($urandom), aalc_pkg::TEMP_W'($urandom));
			random_readings(90);
		end
		apply_calibration(aalc_pkg::CAL_SAMPLE_LOW_RST, aalc_pkg::CAL_TEMP_LOW_RST,
			aalc_pkg::CAL_SAMPLE_HIGH_RST, aalc_pkg::CAL_TEMP_HIGH_RST);
		idle_on = 1'b0;
		random_readings(90);

		@(negedge clk);
		reply_valid = 1'b0;
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d results over %0d calibration settings, with one long output hold.",
			results_checked, settings_used);
		$display("Results with clipped temperature: %0d, with undefined line: %0d.",
			saturations, fit_errors);
		if (mismatches == 0 && outstanding == 0) begin
			$display("adc_average_linear_calibration_unit_tb OK");
		end else begin
			$display("adc_average_linear_calibration_unit_tb NOT OK");
		end
		$finish;
	end

	initial begin : watchdog
		#1000000;
		$display("adc_average_linear_calibration_unit_tb NOT OK");
		$finish;
	end

endmodule

// File: files.f
sv/aalc_pkg.sv
sv/aalc_ram.sv
sv/aalc_div.sv
sv/adc_average_linear_calibration_unit.sv
sv/aalc_checker.sv
tb/sv/aalc_reading_checker.sv
tb/sv/adc_average_linear_calibration_unit_tb.sv
